// ----- sv/h2r_pkg.sv -----
package h2r_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int UNIT_W        = 9;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;

    localparam int UNIT_ONE = 256;
    localparam int UNIT_SH  = 8;
    localparam int CHAN_MAX = 255;

    // one 60-degree sector in hue units
    localparam int SECTOR  = 60 << HUE_FRAC_BITS;
    localparam int SECT_W  = $clog2(SECTOR + 1);
    localparam int R_W     = $clog2(2 * SECTOR);
    localparam int NPAIR   = ((1 << HUE_W) - 1) / (2 * SECTOR);
    localparam int NSECT   = 6;

    localparam int C_W     = 2 * UNIT_SH + 1;
    localparam int NUM_W   = SECT_W + C_W;
    localparam int X_W     = NUM_W + CH_W;

    // SECTOR * 2^16 = 15 * 2^(HUE_FRAC_BITS + 18)
    localparam int SCL_SH  = HUE_FRAC_BITS + 18;
    localparam int Y_W     = 12;
    localparam int RECIP    = 4370;
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 16;
    localparam int Q_W      = Y_W + RECIP_W;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [C_W-1:0]    chroma;
        logic [C_W-1:0]    offset;
        logic [SECT_W-1:0] ramp;
        sector_t           sector;
    } front_t;

    typedef struct packed {
        logic [NUM_CH-1:0][Y_W-1:0] scaled;
    } mix_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

endpackage

// ----- sv/h2r_front.sv -----
module h2r_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [h2r_pkg::HUE_W-1:0]     hue,
    input  logic [h2r_pkg::UNIT_W-1:0]    sat,
    input  logic [h2r_pkg::UNIT_W-1:0]    brightness,
    output logic                          out_valid,
    input  logic                          out_ready,
    output h2r_pkg::front_t               out_data
);

    logic                              v1_reg;
    logic                              v2_reg;
    logic                              rdy1;
    logic                              rdy2;

    logic [h2r_pkg::UNIT_W-1:0]        sat_c;
    logic [h2r_pkg::UNIT_W-1:0]        bri_c;
    logic [h2r_pkg::HUE_W-1:0]         r_full;

    logic [h2r_pkg::C_W-1:0]           c1_next;
    logic [h2r_pkg::C_W-1:0]           c1_reg;
    logic [h2r_pkg::UNIT_W-1:0]        bri1_next;
    logic [h2r_pkg::UNIT_W-1:0]        bri1_reg;
    logic [h2r_pkg::R_W-1:0]           r1_next;
    logic [h2r_pkg::R_W-1:0]           r1_reg;
    h2r_pkg::sector_t                  sec1_next;
    h2r_pkg::sector_t                  sec1_reg;

    logic [h2r_pkg::R_W-1:0]           ctr_dist;
    h2r_pkg::front_t                   f2_next;
    h2r_pkg::front_t                   f2_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: clamp, chroma product, sector and position in sector pair
    always_comb
    begin
        sat_c = (sat > h2r_pkg::UNIT_W'(h2r_pkg::UNIT_ONE)) ?
                h2r_pkg::UNIT_W'(h2r_pkg::UNIT_ONE) : sat;
        bri_c = (brightness > h2r_pkg::UNIT_W'(h2r_pkg::UNIT_ONE)) ?
                h2r_pkg::UNIT_W'(h2r_pkg::UNIT_ONE) : brightness;
        c1_next   = h2r_pkg::C_W'(sat_c) * h2r_pkg::C_W'(bri_c);
        bri1_next = bri_c;

        sec1_next = h2r_pkg::SEC_RED_YEL;
        for (int k = 1; k < h2r_pkg::NSECT; k++)
        begin
            if (hue >= h2r_pkg::HUE_W'(k * h2r_pkg::SECTOR))
            begin
                sec1_next = h2r_pkg::sector_t'(3'(k));
            end
        end

        r_full = hue;
        for (int k = 1; k <= h2r_pkg::NPAIR; k++)
        begin
            if (hue >= h2r_pkg::HUE_W'(k * 2 * h2r_pkg::SECTOR))
            begin
                r_full = hue - h2r_pkg::HUE_W'(k * 2 * h2r_pkg::SECTOR);
            end
        end
        r1_next = r_full[h2r_pkg::R_W-1:0];
    end

    // stage 2: ramp weight and black offset
    always_comb
    begin
        ctr_dist = (r1_reg >= h2r_pkg::R_W'(h2r_pkg::SECTOR)) ?
                   r1_reg - h2r_pkg::R_W'(h2r_pkg::SECTOR) :
                   h2r_pkg::R_W'(h2r_pkg::SECTOR) - r1_reg;
        f2_next.chroma = c1_reg;
        f2_next.offset = (h2r_pkg::C_W'(bri1_reg) << h2r_pkg::UNIT_SH) - c1_reg;
        f2_next.ramp   = h2r_pkg::SECT_W'(h2r_pkg::SECTOR) -
                         h2r_pkg::SECT_W'(ctr_dist);
        f2_next.sector = sec1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            c1_reg   <= c1_next;
            bri1_reg <= bri1_next;
            r1_reg   <= r1_next;
            sec1_reg <= sec1_next;
        end
        if (rdy2 && v1_reg)
        begin
            f2_reg <= f2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = f2_reg;

endmodule

// ----- sv/h2r_mix.sv -----
module h2r_mix
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  h2r_pkg::front_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output h2r_pkg::mix_t        out_data
);

    logic                                          v3_reg;
    logic                                          v4_reg;
    logic                                          rdy3;
    logic                                          rdy4;

    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::SECT_W-1:0] weight;
    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::NUM_W-1:0]  prod_next;
    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::NUM_W-1:0]  prod_reg;
    logic [h2r_pkg::NUM_W-1:0]                       base_next;
    logic [h2r_pkg::NUM_W-1:0]                       base_reg;

    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::NUM_W-1:0]  num;
    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::X_W-1:0]    wide;
    h2r_pkg::mix_t                                   m4_next;
    h2r_pkg::mix_t                                   m4_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    // stage 3: sector select and weight * chroma, offset * sector width
    always_comb
    begin
        case (in_data.sector)
            h2r_pkg::SEC_RED_YEL:
            begin
                weight[0] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
                weight[1] = in_data.ramp;
                weight[2] = '0;
            end
            h2r_pkg::SEC_YEL_GRN:
            begin
                weight[0] = in_data.ramp;
                weight[1] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
                weight[2] = '0;
            end
            h2r_pkg::SEC_GRN_CYN:
            begin
                weight[0] = '0;
                weight[1] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
                weight[2] = in_data.ramp;
            end
            h2r_pkg::SEC_CYN_BLU:
            begin
                weight[0] = '0;
                weight[1] = in_data.ramp;
                weight[2] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
            end
            h2r_pkg::SEC_BLU_MAG:
            begin
                weight[0] = in_data.ramp;
                weight[1] = '0;
                weight[2] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
            end
            default:
            begin
                weight[0] = h2r_pkg::SECT_W'(h2r_pkg::SECTOR);
                weight[1] = '0;
                weight[2] = in_data.ramp;
            end
        endcase

        for (int ch = 0; ch < h2r_pkg::NUM_CH; ch++)
        begin
            prod_next[ch] = h2r_pkg::NUM_W'(weight[ch]) *
                            h2r_pkg::NUM_W'(in_data.chroma);
        end
        base_next = h2r_pkg::NUM_W'(in_data.offset) *
                    h2r_pkg::NUM_W'(h2r_pkg::SECTOR);
    end

    // stage 4: sum, times 255, drop the power-of-two part of the divisor
    always_comb
    begin
        for (int ch = 0; ch < h2r_pkg::NUM_CH; ch++)
        begin
            num[ch]  = prod_reg[ch] + base_reg;
            wide[ch] = h2r_pkg::X_W'(num[ch]) * h2r_pkg::X_W'(h2r_pkg::CHAN_MAX);
            m4_next.scaled[ch] = wide[ch][h2r_pkg::SCL_SH +: h2r_pkg::Y_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            prod_reg <= prod_next;
            base_reg <= base_next;
        end
        if (rdy4 && v3_reg)
        begin
            m4_reg <= m4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = m4_reg;

endmodule

// ----- sv/h2r_scale.sv -----
module h2r_scale
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  h2r_pkg::mix_t        in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output h2r_pkg::rgb_t        out_data
);

    localparam int QT_W = h2r_pkg::Q_W - h2r_pkg::RECIP_SH;

    logic                                             v5_reg;
    logic                                             rdy5;
    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::Q_W-1:0]     prod;
    logic [h2r_pkg::NUM_CH-1:0][QT_W-1:0]             quot;
    logic [h2r_pkg::NUM_CH-1:0][h2r_pkg::CH_W-1:0]    chan;
    h2r_pkg::rgb_t                                    rgb_next;
    h2r_pkg::rgb_t                                    rgb_reg;

    assign rdy5     = !v5_reg || out_ready;
    assign in_ready = rdy5;

    // divide by 15 through reciprocal, exact for 12-bit inputs
    always_comb
    begin
        for (int ch = 0; ch < h2r_pkg::NUM_CH; ch++)
        begin
            prod[ch] = h2r_pkg::Q_W'(in_data.scaled[ch]) *
                       h2r_pkg::Q_W'(h2r_pkg::RECIP);
            quot[ch] = prod[ch][h2r_pkg::RECIP_SH +: QT_W];
            chan[ch] = (quot[ch] > QT_W'(h2r_pkg::CHAN_MAX)) ?
                       h2r_pkg::CH_W'(h2r_pkg::CHAN_MAX) : quot[ch][h2r_pkg::CH_W-1:0];
        end
        rgb_next.red   = chan[0];
        rgb_next.green = chan[1];
        rgb_next.blue  = chan[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (rdy5)
        begin
            v5_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && in_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = rgb_reg;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB converter. Takes one item per cycle while the output is not
// stalled (hue in degrees with six fraction bits, saturation and brightness
// on a 0..256 scale where 256 is full) and returns 8-bit red, green and blue,
// truncated. Sat and brightness above 256 are treated as 256; hue at or past
// 360 degrees stays in the magenta-red sector. There are five pipeline
// registers, one per stage: clamp and chroma product, ramp and offset, weight
// products, scaling by 255, and the final divide by 15 through a reciprocal
// multiply. Every stage holds its item under backpressure and bubbles close
// up, so a stalled output costs no throughput once it drains.
module hsv_to_rgb_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // hue[14:0], sat[23:15], brightness[32:24], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic                 front_valid;
    logic                 front_ready;
    h2r_pkg::front_t      front_data;
    logic                 mix_valid;
    logic                 mix_ready;
    h2r_pkg::mix_t        mix_data;
    h2r_pkg::rgb_t        rgb;

    h2r_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[14:0]),
        .sat        (s_axis_tdata[23:15]),
        .brightness (s_axis_tdata[32:24]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    h2r_mix u_mix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (front_ready),
        .in_data    (front_data),
        .out_valid  (mix_valid),
        .out_ready  (mix_ready),
        .out_data   (mix_data)
    );

    h2r_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mix_valid),
        .in_ready   (mix_ready),
        .in_data    (mix_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (rgb)
    );

    assign m_axis_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule

// ----- tb/sv/tb_hsv_to_rgb_converter.sv -----
module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_COLORS = 1000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [h2r_pkg::HUE_W-1:0]  hue;
        logic [h2r_pkg::UNIT_W-1:0] sat;
        logic [h2r_pkg::UNIT_W-1:0] brt;
        logic                       known;
        h2r_pkg::rgb_t              want;
    } hsv_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // hue[14:0], sat[23:15], brightness[32:24], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]

    logic          quiet = 1'b0;
    int            bad_count = 0;
    int            cycles = 0;
    h2r_pkg::rgb_t pending_rgb[$];
    hsv_row_t      directed_rows[$];

    hsv_to_rgb_converter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // floor((weight*c + m*P) * 255 / (P * 2^16)), capped
    function automatic logic [h2r_pkg::CH_W-1:0] channel_level(
        input longint unsigned weight,
        input longint unsigned chroma,
        input longint unsigned offset,
        input longint unsigned p);
        longint unsigned q;
        q = ((weight * chroma + offset * p) * h2r_pkg::CHAN_MAX) / (p * 64'd65536);
        if (q > h2r_pkg::CHAN_MAX)
            q = h2r_pkg::CHAN_MAX;
        return q[h2r_pkg::CH_W-1:0];
    endfunction

    function automatic h2r_pkg::rgb_t hsv_color(input logic [h2r_pkg::HUE_W-1:0] hue,
                                                input logic [h2r_pkg::UNIT_W-1:0] sat,
                                                input logic [h2r_pkg::UNIT_W-1:0] brt);
        longint unsigned p;
        longint unsigned s;
        longint unsigned v;
        longint unsigned chroma;
        longint unsigned offset;
        longint unsigned r;
        longint unsigned d;
        longint unsigned wx;
        longint unsigned sec;
        longint unsigned wr;
        longint unsigned wg;
        longint unsigned wb;
        h2r_pkg::rgb_t   res;
        p = 64'd60 << h2r_pkg::HUE_FRAC_BITS;
        s = (sat > h2r_pkg::UNIT_ONE) ? h2r_pkg::UNIT_ONE : sat;
        v = (brt > h2r_pkg::UNIT_ONE) ? h2r_pkg::UNIT_ONE : brt;
        chroma = s * v;
        offset = v * h2r_pkg::UNIT_ONE - chroma;
        r = hue % (2 * p);
        d = (r >= p) ? (r - p) : (p - r);
        wx = p - d;
        sec = hue / p;
        if (sec > 5)
            sec = 5;
        case (h2r_pkg::sector_t'(sec[2:0]))
            h2r_pkg::SEC_RED_YEL: begin wr = p;  wg = wx; wb = 0;  end
            h2r_pkg::SEC_YEL_GRN: begin wr = wx; wg = p;  wb = 0;  end
            h2r_pkg::SEC_GRN_CYN: begin wr = 0;  wg = p;  wb = wx; end
            h2r_pkg::SEC_CYN_BLU: begin wr = 0;  wg = wx; wb = p;  end
            h2r_pkg::SEC_BLU_MAG: begin wr = wx; wg = 0;  wb = p;  end
            default:              begin wr = p;  wg = 0;  wb = wx; end
        endcase
        res.red   = channel_level(wr, chroma, offset, p);
        res.green = channel_level(wg, chroma, offset, p);
        res.blue  = channel_level(wb, chroma, offset, p);
        return res;
    endfunction

    function automatic hsv_row_t color_row(input int hue, input int sat, input int brt,
                                           input bit known = 1'b0, input int red = 0,
                                           input int green = 0, input int blue = 0);
        hsv_row_t row;
        row.hue        = hue[h2r_pkg::HUE_W-1:0];
        row.sat        = sat[h2r_pkg::UNIT_W-1:0];
        row.brt        = brt[h2r_pkg::UNIT_W-1:0];
        row.known      = known;
        row.want.red   = red[h2r_pkg::CH_W-1:0];
        row.want.green = green[h2r_pkg::CH_W-1:0];
        row.want.blue  = blue[h2r_pkg::CH_W-1:0];
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        bad_count++;
    endtask

    task automatic push_color(input hsv_row_t row);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 8)
            gap = $urandom_range(1, 2);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, row.brt, row.sat, row.hue};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_rgb.push_back(row.known ? row.want : hsv_color(row.hue, row.sat, row.brt));
    endtask

    always @(posedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 10);
    end

    always @(posedge clk)
    begin
        h2r_pkg::rgb_t got;
        h2r_pkg::rgb_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_rgb.size() == 0)
                flag_mismatch("unexpected item", 1, 0);
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                    flag_mismatch("red", got.red, want.red);
                if (got.green !== want.green)
                    flag_mismatch("green", got.green, want.green);
                if (got.blue !== want.blue)
                    flag_mismatch("blue", got.blue, want.blue);
            end
        end
    end

    initial
    begin
        hsv_row_t row;
        int       hue;
        int       sat;
        int       brt;
        int       waited;

        // primaries and secondaries at sector starts
        directed_rows.push_back(color_row(0,     256, 256, 1, 255, 0,   0));
        directed_rows.push_back(color_row(3840,  256, 256, 1, 255, 255, 0));
        directed_rows.push_back(color_row(7680,  256, 256, 1, 0,   255, 0));
        directed_rows.push_back(color_row(11520, 256, 256, 1, 0,   255, 255));
        directed_rows.push_back(color_row(15360, 256, 256, 1, 0,   0,   255));
        directed_rows.push_back(color_row(19200, 256, 256, 1, 255, 0,   255));
        // gray axis and clamping
        directed_rows.push_back(color_row(0,     0,   256, 1, 255, 255, 255));
        directed_rows.push_back(color_row(12345, 256, 0,   1, 0,   0,   0));
        directed_rows.push_back(color_row(0,     0,   0,   1, 0,   0,   0));
        directed_rows.push_back(color_row(32767, 511, 0,   1, 0,   0,   0));
        directed_rows.push_back(color_row(0,     511, 511, 1, 255, 0,   0));
        directed_rows.push_back(color_row(0,     128, 256, 1, 255, 127, 127));
        // sector edges, hue past 360, odd sizes
        directed_rows.push_back(color_row(3839,  256, 256));
        directed_rows.push_back(color_row(7679,  1,   256));
        directed_rows.push_back(color_row(1920,  256, 256));
        directed_rows.push_back(color_row(23039, 256, 256));
        directed_rows.push_back(color_row(23040, 256, 256));
        directed_rows.push_back(color_row(32767, 256, 256));
        directed_rows.push_back(color_row(30000, 200, 300));
        directed_rows.push_back(color_row(9000,  257, 100));
        directed_rows.push_back(color_row(16384, 255, 255));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            push_color(directed_rows[k]);

        for (int i = 0; i < RANDOM_COLORS; i++)
        begin
            quiet <= (i >= 400 && i < 600);
            if ($urandom_range(99) < 10)
                hue = $urandom_range((1 << h2r_pkg::HUE_W) - 1);
            else
                hue = $urandom_range(360 * (1 << h2r_pkg::HUE_FRAC_BITS) - 1);
            sat = ($urandom_range(99) < 10) ? $urandom_range(511) : $urandom_range(256);
            brt = ($urandom_range(99) < 10) ? $urandom_range(511) : $urandom_range(256);
            if ($urandom_range(99) < 5)
                sat = $urandom_range(1) ? 256 : 0;
            if ($urandom_range(99) < 5)
                brt = $urandom_range(1) ? 256 : 0;
            row = color_row(hue, sat, brt);
            push_color(row);
        end
        quiet <= 1'b0;
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending_rgb.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rgb.size() != 0)
            flag_mismatch("items never returned", pending_rgb.size(), 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
